FILE: design/csivpd_pkg.sv
// shared types, constants and functions of the variance presence detector
// depends on nothing; used by every module of the block
package csivpd_pkg;

    localparam int WINDOW_ROWS_DEF = 30;
    localparam int SUBCARRIERS_DEF = 64;

    localparam int SRC_W      = 48;
    localparam int LEN_W      = 10;
    localparam int SCN_W      = 6;
    localparam int IQ_W       = 8;
    localparam int THR_W      = 24;
    localparam int ROWS_OUT_W = 5;
    localparam int AMP_W      = 16;
    localparam int AMP_MAX    = 46340;
    localparam longint AMP_SQ_MAX = 64'd2147395600;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam logic [SRC_W-1:0] RST_SOURCE      = '0;
    localparam logic [LEN_W-1:0] RST_MIN_LEN     = 10'd128;
    localparam logic [THR_W-1:0] RST_THRESHOLD   = 24'd896;
    localparam logic [SCN_W-1:0] RST_BAND_FIRST  = 6'd6;
    localparam logic [SCN_W-1:0] RST_BAND_LAST   = 6'd57;
    localparam logic [SCN_W-1:0] RST_NOTCH_FIRST = 6'd28;
    localparam logic [SCN_W-1:0] RST_NOTCH_LAST  = 6'd36;

    localparam int SQRT_CYCLES = 8;
    localparam int SQRT_CNT_W  = 4;

    typedef enum logic [2:0] {
        REG_SOURCE      = 3'd0,
        REG_MIN_LEN     = 3'd1,
        REG_THRESHOLD   = 3'd2,
        REG_BAND_FIRST  = 3'd3,
        REG_BAND_LAST   = 3'd4,
        REG_NOTCH_FIRST = 3'd5,
        REG_NOTCH_LAST  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic [LEN_W-1:0] min_len;
        logic [THR_W-1:0] threshold;
        logic [SCN_W-1:0] band_first;
        logic [SCN_W-1:0] band_last;
        logic [SCN_W-1:0] notch_first;
        logic [SCN_W-1:0] notch_last;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic rd_ent;
        logic sqrt_step;
        logic square;
        logic update;
        logic advance;
        logic mean_issue;
        logic div_start;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic sqrt_last;
        logic last_sc;
        logic full_next;
        logic k_last;
        logic pipe_busy;
        logic div_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [31:0] v;
        logic [31:0] root;
        logic [31:0] pos;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       r;
        logic [31:0] trial;
        trial = s.root + s.pos;
        r     = s;
        if (s.v >= trial) begin
            r.v    = s.v - trial;
            r.root = (s.root >> 1) + s.pos;
        end else begin
            r.root = s.root >> 1;
        end
        r.pos = s.pos >> 2;
        return r;
    endfunction

endpackage

FILE: design/csivpd_ctrl.sv
// controller state machine of the variance presence detector
// depends on csivpd_pkg; drives commands into csivpd_dp
module csivpd_ctrl
    import csivpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILT, S_SQRT, S_SQ, S_UPD, S_ADV, S_MEAN, S_DRAIN, S_DIV, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: begin
                if (i_status.pass) begin
                    o_cmd.rd_ent = 1'b1;
                    n_state      = S_SQRT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.last_sc ? S_ADV : S_IDLE;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = i_status.full_next ? S_MEAN : S_EMIT;
            end
            S_MEAN: begin
                o_cmd.mean_issue = 1'b1;
                if (i_status.k_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/csivpd_dp.sv
// datapath of the variance presence detector: amplitude root, ring window,
// per-subcarrier sums, band walk, divider and result register; uses csivpd_pkg
module csivpd_dp
    import csivpd_pkg::*;
#(
    parameter int WINDOW_ROWS = WINDOW_ROWS_DEF,
    parameter int SUBCARRIERS = SUBCARRIERS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  t_cfg                         i_cfg,
    input  logic        [SRC_W-1:0]      i_source_address,
    input  logic        [LEN_W-1:0]      i_packet_length,
    input  logic        [SCN_W-1:0]      i_subcarrier_number,
    input  logic signed [IQ_W-1:0]       i_imag_part,
    input  logic signed [IQ_W-1:0]       i_real_part,
    input  logic                         i_out_stall,
    output t_status                      o_status,
    output logic                         o_out_valid,
    output logic                         o_window_filled,
    output logic        [ROWS_OUT_W-1:0] o_rows_collected,
    output logic        [THR_W-1:0]      o_mean_variance,
    output logic                         o_presence
);

    localparam int ROW_W   = $clog2(WINDOW_ROWS);
    localparam int SC_W    = $clog2(SUBCARRIERS);
    localparam int WA_W    = $clog2(WINDOW_ROWS * SUBCARRIERS);
    localparam int NV_W    = $clog2(WINDOW_ROWS + 1);
    localparam int CNT_W   = $clog2(SUBCARRIERS + 1);
    localparam int S1_W    = $clog2(WINDOW_ROWS * AMP_MAX + 1);
    localparam longint S2_MAX = longint'(WINDOW_ROWS) * AMP_SQ_MAX;
    localparam int S2_W    = $clog2(S2_MAX + 1);
    localparam longint P1_MAX = longint'(WINDOW_ROWS) * WINDOW_ROWS * AMP_SQ_MAX;
    localparam int P1_W    = $clog2(P1_MAX + 1);
    localparam int ACC_W   = P1_W + CNT_W;
    localparam int DIV_W   = ACC_W - 8;
    localparam int DEN_W   = $clog2(WINDOW_ROWS * WINDOW_ROWS * SUBCARRIERS + 1);
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int NN      = WINDOW_ROWS * WINDOW_ROWS;

    // sample registers
    logic                r_pass;
    logic [SCN_W-1:0]    r_sc;
    t_sqrt               r_sq;
    logic [SQRT_CNT_W-1:0] r_scnt;
    logic [AMP_W-1:0]    r_amp;
    logic [2*AMP_W-1:0]  r_amp_sq;
    logic [2*AMP_W-1:0]  r_old_sq;
    logic [AMP_W-1:0]    r_old;

    // window and sums
    logic [AMP_W-1:0]    mem_win [WINDOW_ROWS*SUBCARRIERS];
    logic [S1_W-1:0]     mem_s1  [SUBCARRIERS];
    logic [S2_W-1:0]     mem_s2  [SUBCARRIERS];
    logic [SUBCARRIERS-1:0] r_sval;
    logic [SUBCARRIERS-1:0] r_row_wr;
    logic [AMP_W-1:0]    r_win_q;
    logic [S1_W-1:0]     r_s1_q;
    logic [S2_W-1:0]     r_s2_q;
    logic                r_sv_q;
    logic [ROW_W-1:0]    r_row;
    logic                r_full;

    // band walk
    logic [SC_W-1:0]     r_k;
    logic                r_v1;
    logic                r_v2;
    logic                r_inb1;
    logic                r_inb2;
    logic [P1_W-1:0]     r_p1;
    logic [P1_W-1:0]     r_p2;
    logic [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_cnt;

    // divider
    logic [DIV_W-1:0]    r_quo;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [DCNT_W-1:0]   r_dcnt;

    // result
    logic                r_out_valid;
    logic                r_o_filled;
    logic [ROWS_OUT_W-1:0] r_o_rows;
    logic [THR_W-1:0]    r_o_mv;
    logic                r_o_pres;

    logic signed [2*IQ_W-1:0] re_sq;
    logic signed [2*IQ_W-1:0] im_sq;
    logic [2*IQ_W-1:0]   power;
    logic [WA_W-1:0]     win_addr;
    logic [SC_W-1:0]     sum_addr;
    logic [SC_W-1:0]     sc_idx;
    logic [AMP_W-1:0]    amp;
    logic [AMP_W-1:0]    old;
    logic [S1_W-1:0]     s1v;
    logic [S2_W-1:0]     s2v;
    logic [2*S1_W-1:0]   s1_sq;
    logic [S2_W+NV_W-1:0] s2_n;
    logic [SCN_W-1:0]    k6;
    logic                in_band;
    logic [DEN_W:0]      trial;
    logic                fits;
    logic [THR_W-1:0]    mv_sat;

    assign re_sq    = i_real_part * i_real_part;
    assign im_sq    = i_imag_part * i_imag_part;
    assign power    = $unsigned(re_sq) + $unsigned(im_sq);
    assign sc_idx   = r_sc[SC_W-1:0];
    assign win_addr = WA_W'(r_row) * WA_W'(SUBCARRIERS) + WA_W'(sc_idx);
    assign sum_addr = i_cmd.mean_issue ? r_k : sc_idx;
    assign amp      = r_sq.root[AMP_W-1:0];
    // entry of the current row already written on this lap, or window full
    assign old      = (r_full || r_row_wr[sc_idx]) ? r_win_q : '0;
    assign s1v      = r_sv_q ? r_s1_q : '0;
    assign s2v      = r_sv_q ? r_s2_q : '0;
    assign s1_sq    = s1v * s1v;
    assign s2_n     = s2v * NV_W'(WINDOW_ROWS);
    assign k6       = SCN_W'(r_k);
    assign in_band  = (k6 >= i_cfg.band_first) && (k6 <= i_cfg.band_last)
                   && !((k6 >= i_cfg.notch_first) && (k6 <= i_cfg.notch_last));
    assign trial    = {r_rem, r_quo[DIV_W-1]};
    assign fits     = (trial >= {1'b0, r_den});
    assign mv_sat   = (r_cnt == '0) ? '0
                    : (|r_quo[DIV_W-1:THR_W]) ? '1 : r_quo[THR_W-1:0];

    assign o_status.pass      = r_pass;
    assign o_status.sqrt_last = (r_scnt == SQRT_CNT_W'(1));
    assign o_status.last_sc   = (r_sc == SCN_W'(SUBCARRIERS - 1));
    assign o_status.full_next = r_full || (r_row == ROW_W'(WINDOW_ROWS - 1));
    assign o_status.k_last    = (r_k == SC_W'(SUBCARRIERS - 1));
    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.div_last  = (r_dcnt == DCNT_W'(1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_window_filled  = r_o_filled;
    assign o_rows_collected = r_o_rows;
    assign o_mean_variance  = r_o_mv;
    assign o_presence       = r_o_pres;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            mem_win[win_addr] <= amp;
            mem_s1[sc_idx]    <= s1v - S1_W'(r_old) + S1_W'(r_amp);
            mem_s2[sc_idx]    <= s2v - S2_W'(r_old_sq) + S2_W'(r_amp_sq);
        end
        if (i_cmd.rd_ent) begin
            r_win_q <= mem_win[win_addr];
        end
        if (i_cmd.rd_ent || i_cmd.mean_issue) begin
            r_s1_q <= mem_s1[sum_addr];
            r_s2_q <= mem_s2[sum_addr];
            r_sv_q <= r_sval[sum_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pass <= (i_source_address == i_cfg.source)
                   && (i_packet_length >= i_cfg.min_len)
                   && ({1'b0, i_subcarrier_number} < 7'(SUBCARRIERS));
            r_sc   <= i_subcarrier_number;
            r_sq.v    <= {power, 16'h0000};
            r_sq.root <= '0;
            r_sq.pos  <= 32'h4000_0000;
            r_scnt    <= SQRT_CNT_W'(SQRT_CYCLES);
        end
        if (i_cmd.sqrt_step) begin
            r_sq   <= sqrt_step(sqrt_step(r_sq));
            r_scnt <= r_scnt - 1'b1;
        end
        if (i_cmd.square) begin
            r_amp    <= amp;
            r_old    <= old;
            r_amp_sq <= amp * amp;
            r_old_sq <= old * old;
        end
        if (i_cmd.advance) begin
            r_k   <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mean_issue) begin
            r_k    <= r_k + 1'b1;
            r_inb1 <= in_band;
        end
        if (r_v1) begin
            r_p1   <= P1_W'(s2_n);
            r_p2   <= P1_W'(s1_sq);
            r_inb2 <= r_inb1;
        end
        if (r_v2 && r_inb2) begin
            r_acc <= r_acc + ACC_W'(r_p1) - ACC_W'(r_p2);
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_quo  <= r_acc[ACC_W-1:8];
            r_rem  <= '0;
            r_den  <= DEN_W'(NN) * DEN_W'(r_cnt);
            r_dcnt <= DCNT_W'(DIV_W);
        end
        if (i_cmd.div_step) begin
            r_rem  <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quo  <= {r_quo[DIV_W-2:0], fits};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_filled <= r_full;
            r_o_rows   <= ROWS_OUT_W'(r_row);
            r_o_mv     <= r_full ? mv_sat : '0;
            r_o_pres   <= r_full && (mv_sat > i_cfg.threshold);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval      <= '0;
            r_row_wr    <= '0;
            r_row       <= '0;
            r_full      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) r_sval[sc_idx] <= 1'b1;
            if (i_cmd.advance) begin
                r_row_wr <= '0;
            end else if (i_cmd.update) begin
                r_row_wr[sc_idx] <= 1'b1;
            end
            if (i_cmd.advance) begin
                if (r_row == ROW_W'(WINDOW_ROWS - 1)) begin
                    r_row  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
            r_v1 <= i_cmd.mean_issue;
            r_v2 <= r_v1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: design/csi_variance_presence_detector.sv
// top level of the variance presence detector: register port, controller, datapath
// depends on csivpd_pkg, csivpd_ctrl and csivpd_dp
//
// A sample from a foreign or short packet is accepted, filtered and dropped. A counted
// sample is accepted, filtered together with the memory read, then passes the amplitude
// square root (two result bits per cycle), squaring, and the update of the window row
// and the subcarrier sums. The packet's last sample adds the advance of the row pointer
// and, once the window is full, a walk over all SUBCARRIERS sums through a three-stage
// multiply and accumulate pipe and a one-bit-per-cycle divider before the result is
// loaded. Inputs stall while a sample is in work. The result register holds one
// result; the next one waits in place until it is taken. No clearing pass follows reset.
module csi_variance_presence_detector
    import csivpd_pkg::*;
#(
    parameter int WINDOW_ROWS = WINDOW_ROWS_DEF,
    parameter int SUBCARRIERS = SUBCARRIERS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [CFG_ADDR_W-1:0] paddr,
    input  logic        [CFG_DATA_W-1:0] pwdata,
    output logic        [CFG_DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic        [SRC_W-1:0]      i_source_address,
    input  logic        [LEN_W-1:0]      i_packet_length,
    input  logic        [SCN_W-1:0]      i_subcarrier_number,
    input  logic signed [IQ_W-1:0]       i_imag_part,
    input  logic signed [IQ_W-1:0]       i_real_part,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_window_filled,
    output logic        [ROWS_OUT_W-1:0] o_rows_collected,
    output logic        [THR_W-1:0]      o_mean_variance,
    output logic                         o_presence
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source      <= RST_SOURCE;
            r_cfg.min_len     <= RST_MIN_LEN;
            r_cfg.threshold   <= RST_THRESHOLD;
            r_cfg.band_first  <= RST_BAND_FIRST;
            r_cfg.band_last   <= RST_BAND_LAST;
            r_cfg.notch_first <= RST_NOTCH_FIRST;
            r_cfg.notch_last  <= RST_NOTCH_LAST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SOURCE:      r_cfg.source      <= pwdata[SRC_W-1:0];
                REG_MIN_LEN:     r_cfg.min_len     <= pwdata[LEN_W-1:0];
                REG_THRESHOLD:   r_cfg.threshold   <= pwdata[THR_W-1:0];
                REG_BAND_FIRST:  r_cfg.band_first  <= pwdata[SCN_W-1:0];
                REG_BAND_LAST:   r_cfg.band_last   <= pwdata[SCN_W-1:0];
                REG_NOTCH_FIRST: r_cfg.notch_first <= pwdata[SCN_W-1:0];
                REG_NOTCH_LAST:  r_cfg.notch_last  <= pwdata[SCN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SOURCE:      prdata = CFG_DATA_W'(r_cfg.source);
            REG_MIN_LEN:     prdata = CFG_DATA_W'(r_cfg.min_len);
            REG_THRESHOLD:   prdata = CFG_DATA_W'(r_cfg.threshold);
            REG_BAND_FIRST:  prdata = CFG_DATA_W'(r_cfg.band_first);
            REG_BAND_LAST:   prdata = CFG_DATA_W'(r_cfg.band_last);
            REG_NOTCH_FIRST: prdata = CFG_DATA_W'(r_cfg.notch_first);
            REG_NOTCH_LAST:  prdata = CFG_DATA_W'(r_cfg.notch_last);
            default:         prdata = '0;
        endcase
    end

    csivpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    csivpd_dp #(
        .WINDOW_ROWS (WINDOW_ROWS),
        .SUBCARRIERS (SUBCARRIERS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg               (r_cfg),
        .i_source_address    (i_source_address),
        .i_packet_length     (i_packet_length),
        .i_subcarrier_number (i_subcarrier_number),
        .i_imag_part         (i_imag_part),
        .i_real_part         (i_real_part),
        .i_out_stall         (i_out_stall),
        .o_status            (status),
        .o_out_valid         (o_out_valid),
        .o_window_filled     (o_window_filled),
        .o_rows_collected    (o_rows_collected),
        .o_mean_variance     (o_mean_variance),
        .o_presence          (o_presence)
    );

    // a taken transaction blocks the input on the next cycle
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    // no presence before the window has filled
    a_presence_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_presence) |-> o_window_filled)
        else $error("presence flagged while window filling");

    // progress results carry no variance
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_window_filled) |-> (o_mean_variance == '0))
        else $error("variance reported while window filling");

    // a new result is loaded only when the register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten before it was taken");

endmodule

FILE: verif/tb.sv
// self-checking testbench of csi_variance_presence_detector: directed and random sample streams
// depends on csivpd_pkg and the csi_variance_presence_detector rtl
`timescale 1ns / 1ps

module tb;
    import csivpd_pkg::*;

    localparam int ROWS = WINDOW_ROWS_DEF;
    localparam int SCS  = SUBCARRIERS_DEF;
    localparam int LIMIT = 3000000;
    // random packets carry every fourth subcarrier, ending on the highest
    localparam int SC_STRIDE = 4;

    typedef struct {
        logic              filled;
        logic [4:0]        rows;
        logic [THR_W-1:0]  mv;
        logic              pres;
    } t_obs;

    typedef enum {D_FOREIGN, D_SHORT, D_PACKET} t_dkind;

    typedef struct {
        t_dkind            kind;
        logic [LEN_W-1:0]  len;
        logic signed [7:0] im;
        logic signed [7:0] re;
        int                rows;
    } t_drow;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic [SRC_W-1:0] i_source_address = '0;
    logic [LEN_W-1:0] i_packet_length = '0;
    logic [SCN_W-1:0] i_subcarrier_number = '0;
    logic signed [IQ_W-1:0] i_imag_part = '0;
    logic signed [IQ_W-1:0] i_real_part = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    logic o_window_filled;
    logic [ROWS_OUT_W-1:0] o_rows_collected;
    logic [THR_W-1:0] o_mean_variance;
    logic o_presence;

    csi_variance_presence_detector i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // detector model state
    logic [SRC_W-1:0] cfg_source = RST_SOURCE;
    logic [LEN_W-1:0] cfg_min_len = RST_MIN_LEN;
    logic [THR_W-1:0] cfg_threshold = RST_THRESHOLD;
    logic [5:0] cfg_bf = RST_BAND_FIRST, cfg_bl = RST_BAND_LAST;
    logic [5:0] cfg_nf = RST_NOTCH_FIRST, cfg_nl = RST_NOTCH_LAST;
    logic [15:0] amp_window [ROWS][SCS];
    int row_ptr = 0;
    bit win_full = 0;
    longint unsigned amp_sum [SCS];
    longint unsigned sq_sum [SCS];

    t_obs results_due [$];
    int errors = 0, samples = 0, results_seen = 0, settings = 1;
    int sender_idle_pct = 24, rx_stall_pct = 78, hold_left = 0;
    longint cycles = 0;
    logic signed [7:0] base_im [SCS], base_re [SCS];

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [15:0] amplitude(logic signed [7:0] im, logic signed [7:0] re);
        longint unsigned v, root, cand;
        v = longint'(int'(re) * int'(re) + int'(im) * int'(im)) << 16;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root[15:0];
    endfunction

    function automatic logic [THR_W-1:0] band_variance();
        longint unsigned tot, cnt;
        tot = 0;
        cnt = 0;
        for (int k = 0; k < SCS; k++) begin
            if (k < cfg_bf || k > cfg_bl) continue;
            if (k >= cfg_nf && k <= cfg_nl) continue;
            tot += ROWS * sq_sum[k] - amp_sum[k] * amp_sum[k];
            cnt++;
        end
        if (cnt == 0) return '0;
        tot = tot / (ROWS * ROWS * cnt * 256);
        return (tot > 64'hFFFFFF) ? 24'hFFFFFF : tot[23:0];
    endfunction

    // updates the model with one accepted sample; returns 1 when a result follows
    function automatic bit absorb_sample(logic [SRC_W-1:0] src, logic [LEN_W-1:0] len,
                                         logic [5:0] sc, logic signed [7:0] im,
                                         logic signed [7:0] re, output t_obs r);
        longint unsigned a, old;
        if (src != cfg_source || len < cfg_min_len) return 0;
        a = amplitude(im, re);
        old = amp_window[row_ptr][sc];
        amp_sum[sc] = amp_sum[sc] - old + a;
        sq_sum[sc] = sq_sum[sc] - old * old + a * a;
        amp_window[row_ptr][sc] = a[15:0];
        if (sc != SCS - 1) return 0;
        row_ptr = (row_ptr + 1) % ROWS;
        if (row_ptr == 0) win_full = 1;
        r.filled = win_full;
        r.rows = row_ptr[4:0];
        r.mv = win_full ? band_variance() : '0;
        r.pres = win_full && (r.mv > cfg_threshold);
        return 1;
    endfunction

    task automatic send_sample(logic [SRC_W-1:0] src, logic [LEN_W-1:0] len, logic [5:0] sc,
                               logic signed [7:0] im, logic signed [7:0] re,
                               bit typed = 0, t_obs want = '{0, 0, 0, 0});
        t_obs r;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_source_address <= src;
        i_packet_length <= len;
        i_subcarrier_number <= sc;
        i_imag_part <= im;
        i_real_part <= re;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        samples++;
        if (absorb_sample(src, len, sc, im, re, r)) results_due.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    task automatic drain(int settle);
        i_in_valid <= 0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] want;
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        @(negedge i_clk);
        case (idx)
            REG_SOURCE:      cfg_source = val[SRC_W-1:0];
            REG_MIN_LEN:     cfg_min_len = val[LEN_W-1:0];
            REG_THRESHOLD:   cfg_threshold = val[THR_W-1:0];
            REG_BAND_FIRST:  cfg_bf = val[5:0];
            REG_BAND_LAST:   cfg_bl = val[5:0];
            REG_NOTCH_FIRST: cfg_nf = val[5:0];
            REG_NOTCH_LAST:  cfg_nl = val[5:0];
            default: ;
        endcase
        case (idx)
            REG_SOURCE:    want = val & 64'hFFFF_FFFF_FFFF;
            REG_MIN_LEN:   want = val & 64'h3FF;
            REG_THRESHOLD: want = val & 64'hFF_FFFF;
            default:       want = val & 64'h3F;
        endcase
        // read back
        pwrite <= 0;
        penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic set_all(logic [SRC_W-1:0] src, logic [LEN_W-1:0] ml, logic [THR_W-1:0] thr,
                           logic [5:0] bf, logic [5:0] bl, logic [5:0] nf, logic [5:0] nl);
        drain(200);
        write_reg(REG_SOURCE, src);
        write_reg(REG_MIN_LEN, ml);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_BAND_FIRST, bf);
        write_reg(REG_BAND_LAST, bl);
        write_reg(REG_NOTCH_FIRST, nf);
        write_reg(REG_NOTCH_LAST, nl);
        settings++;
        for (int k = 0; k < SCS; k++) begin
            base_im[k] = $urandom_range(200) - 100;
            base_re[k] = $urandom_range(200) - 100;
        end
    endtask

    function automatic logic [SRC_W-1:0] foreign_source();
        logic [SRC_W-1:0] s;
        do s = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF; while (s == cfg_source);
        return s;
    endfunction

    task automatic run_packets(int npk, bit pause_midway);
        int done;
        bit quiet, partial, ignored;
        logic [SRC_W-1:0] src;
        logic [LEN_W-1:0] len;
        logic signed [7:0] im, re;
        done = 0;
        while (done < npk) begin
            if (pause_midway && done == npk / 2) drain(0);
            ignored = $urandom_range(99) < 12;
            partial = !ignored && win_full && $urandom_range(99) < 10;
            quiet = $urandom_range(1);
            src = cfg_source;
            len = $urandom_range(1023, cfg_min_len);
            if (ignored) begin
                if (cfg_min_len > 0 && $urandom_range(1)) len = $urandom_range(cfg_min_len - 1);
                else src = foreign_source();
            end
            for (int sc = 0; sc < SCS; sc++) begin
                if (sc % SC_STRIDE != SC_STRIDE - 1) continue;
                if (partial && $urandom_range(99) < 20) continue;
                if ($urandom_range(99) < 3)
                    send_sample(foreign_source(), $urandom, $urandom, $urandom, $urandom);
                if (quiet) begin
                    im = base_im[sc] + $urandom_range(2) - 1;
                    re = base_re[sc] + $urandom_range(2) - 1;
                end else begin
                    im = $urandom;
                    re = $urandom;
                end
                send_sample(src, len, sc, im, re);
                if (!ignored && sc == SCS - 1) done++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= $urandom_range(99) < rx_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_obs e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("csi_variance_presence_detector verification failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected transaction, rows", o_rows_collected, 0);
            end else begin
                e = results_due.pop_front();
                if (o_window_filled !== e.filled)
                    report_mismatch("window_filled", o_window_filled, e.filled);
                if (o_rows_collected !== e.rows)
                    report_mismatch("rows_collected", o_rows_collected, e.rows);
                if (o_mean_variance !== e.mv)
                    report_mismatch("mean_variance", o_mean_variance, e.mv);
                if (o_presence !== e.pres) report_mismatch("presence", o_presence, e.pres);
            end
        end
    end

    t_drow directed [] = '{
        '{D_FOREIGN, 10'd1023, -8'sd128, 8'sd127, 0},
        '{D_SHORT, 10'd127, 8'sd127, -8'sd128, 0},
        '{D_SHORT, 10'd0, 8'sd0, 8'sd0, 0},
        '{D_FOREIGN, 10'd512, 8'sd127, 8'sd127, 0},
        '{D_PACKET, 10'd128, -8'sd128, -8'sd128, 1},
        '{D_PACKET, 10'd1023, 8'sd127, 8'sd127, 2},
        '{D_PACKET, 10'd128, 8'sd0, 8'sd0, 3},
        '{D_PACKET, 10'd700, -8'sd128, 8'sd0, 4},
        '{D_PACKET, 10'd1023, 8'sd0, 8'sd127, 5}
    };

    initial begin
        for (int k = 0; k < SCS; k++) begin
            amp_sum[k] = 0;
            sq_sum[k] = 0;
            for (int r = 0; r < ROWS; r++) amp_window[r][k] = '0;
            base_im[k] = $urandom_range(200) - 100;
            base_re[k] = $urandom_range(200) - 100;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                D_FOREIGN: send_sample(48'hFFFF_FFFF_FFFF, directed[i].len, 6'd63,
                                       directed[i].im, directed[i].re);
                D_SHORT:   send_sample(RST_SOURCE, directed[i].len, 6'd63,
                                       directed[i].im, directed[i].re);
                default:
                    for (int sc = 0; sc < SCS; sc++)
                        send_sample(RST_SOURCE, directed[i].len, sc, directed[i].im,
                                    directed[i].re, sc == SCS - 1,
                                    '{1'b0, directed[i].rows[4:0], 24'd0, 1'b0});
            endcase
        end

        run_packets(36, 0);
        set_all({$urandom, $urandom}, $urandom_range(1023), $urandom_range(4000),
                6'd0, 6'd63, 6'd40, 6'd20);
        hold_left = 3000;
        run_packets(12, 0);

        sender_idle_pct = 78;
        rx_stall_pct = 24;
        set_all(48'hFFFF_FFFF_FFFF, 10'd1023, 24'hFF_FFFF, 6'd63, 6'd63, 6'd0, 6'd0);
        run_packets(12, 1);
        set_all('0, 10'd0, 24'd0, 6'd10, 6'd5, 6'd0, 6'd63);
        run_packets(8, 0);

        sender_idle_pct = 0;
        rx_stall_pct = 0;
        set_all({$urandom, $urandom}, $urandom_range(1023), $urandom_range(3000),
                $urandom_range(20), $urandom_range(63, 30), $urandom_range(40, 20),
                $urandom_range(45, 25));
        run_packets(14, 0);

        drain(200);
        $display("ran %0d samples under %0d register settings, %0d results checked",
                 samples, settings, results_seen);
        if (errors == 0) begin
            $display("csi_variance_presence_detector verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("csi_variance_presence_detector verification failed");
        end
        $finish;
    end

endmodule
